// ===== design/semv_pkg.sv =====
// Shared types, character codes and helpers for the semantic version checker.
// No dependencies; imported by every module of the block.
package semv_pkg;

    // Default width of the parsed numbers
    localparam int NUM_WIDTH_DEF = 32;

    // Width of one reported number
    localparam int OUT_NUM_W    = 32;
    // major, minor, patch, prerelease flag, build flag
    localparam int OUT_FIELDS_W = 3 * OUT_NUM_W + 2;
    // Padded up to whole bytes
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;

    typedef enum logic [4:0] {
        PH_MAJOR = 5'b00001,
        PH_MINOR = 5'b00010,
        PH_PATCH = 5'b00100,
        PH_PRE   = 5'b01000,
        PH_BUILD = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        DC_NONE = 2'd0,
        DC_ONE  = 2'd1,
        DC_MANY = 2'd2
    } t_dcount;

    typedef struct packed {
        logic                 has_build;
        logic                 has_pre;
        logic [OUT_NUM_W-1:0] patch;
        logic [OUT_NUM_W-1:0] minor;
        logic [OUT_NUM_W-1:0] major;
        logic                 is_valid;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE], [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_DASH};
    endfunction

endpackage

// ===== design/semv_parser.sv =====
// Parse state and per-character update for the semantic version checker.
// Depends on semv_pkg.
module semv_parser #(
    parameter int NUMBER_WIDTH = semv_pkg::NUM_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    output semv_pkg::t_result o_result
);
    import semv_pkg::*;

    localparam int ExtW = NUMBER_WIDTH + 4;
    localparam int OutW = (NUMBER_WIDTH < OUT_NUM_W) ? NUMBER_WIDTH : OUT_NUM_W;

    t_phase                  r_phase, n_phase;
    t_dcount                 r_dcount, n_dcount;
    logic [NUMBER_WIDTH-1:0] r_acc, n_acc;
    logic [NUMBER_WIDTH-1:0] r_major, n_major;
    logic [NUMBER_WIDTH-1:0] r_minor, n_minor;
    logic                    r_first_zero, n_first_zero;
    logic                    r_ovf, n_ovf;
    logic                    r_id_has, n_id_has;
    logic                    r_id_zero, n_id_zero;
    logic                    r_error, n_error;
    logic                    r_pre_seen, n_pre_seen;
    logic                    r_build_seen, n_build_seen;

    logic [ExtW-1:0] ext_acc;
    logic [ExtW-1:0] prod;
    logic [3:0]      digit;
    logic            prod_ovf;
    logic            num_ok;
    logic            in_pre;
    logic            valid;

    // acc * 10 + digit as two shifts and two adds
    assign digit    = 4'(i_char - CH_ZERO);
    assign ext_acc  = {4'b0, r_acc};
    assign prod     = (ext_acc << 3) + (ext_acc << 1) + ExtW'(digit);
    assign prod_ovf = |prod[ExtW-1:NUMBER_WIDTH];
    assign num_ok   = (r_dcount != DC_NONE) && !r_ovf;
    assign in_pre   = (r_phase == PH_PRE);

    always_comb begin
        n_phase      = r_phase;
        n_dcount     = r_dcount;
        n_acc        = r_acc;
        n_major      = r_major;
        n_minor      = r_minor;
        n_first_zero = r_first_zero;
        n_ovf        = r_ovf;
        n_id_has     = r_id_has;
        n_id_zero    = r_id_zero;
        n_error      = r_error;
        n_pre_seen   = r_pre_seen;
        n_build_seen = r_build_seen;

        if (i_step && i_last) begin
            // string closed: back to the reset state
            n_phase      = PH_MAJOR;
            n_dcount     = DC_NONE;
            n_acc        = '0;
            n_major      = '0;
            n_minor      = '0;
            n_first_zero = 1'b0;
            n_ovf        = 1'b0;
            n_id_has     = 1'b0;
            n_id_zero    = 1'b0;
            n_error      = 1'b0;
            n_pre_seen   = 1'b0;
            n_build_seen = 1'b0;
        end else if (i_step && !r_error) begin
            case (r_phase)
                PH_MAJOR, PH_MINOR, PH_PATCH: begin
                    if (is_digit(i_char)) begin
                        if (r_dcount != DC_NONE && r_first_zero) begin
                            n_error = 1'b1;
                        end else begin
                            if (r_dcount == DC_NONE) begin
                                n_first_zero = (i_char == CH_ZERO);
                            end
                            if (prod_ovf) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_acc = prod[NUMBER_WIDTH-1:0];
                            end
                            n_dcount = (r_dcount == DC_NONE) ? DC_ONE : DC_MANY;
                        end
                    end else if (!num_ok) begin
                        n_error = 1'b1;
                    end else if (i_char == CH_DOT && r_phase == PH_MAJOR) begin
                        n_major      = r_acc;
                        n_phase      = PH_MINOR;
                        n_acc        = '0;
                        n_dcount     = DC_NONE;
                        n_first_zero = 1'b0;
                        n_ovf        = 1'b0;
                    end else if (i_char == CH_DOT && r_phase == PH_MINOR) begin
                        n_minor      = r_acc;
                        n_phase      = PH_PATCH;
                        n_acc        = '0;
                        n_dcount     = DC_NONE;
                        n_first_zero = 1'b0;
                        n_ovf        = 1'b0;
                    end else if (i_char == CH_DASH && r_phase == PH_PATCH) begin
                        n_phase    = PH_PRE;
                        n_pre_seen = 1'b1;
                        n_id_has   = 1'b0;
                        n_id_zero  = 1'b0;
                    end else if (i_char == CH_PLUS && r_phase == PH_PATCH) begin
                        n_phase      = PH_BUILD;
                        n_build_seen = 1'b1;
                        n_id_has     = 1'b0;
                        n_id_zero    = 1'b0;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                PH_PRE, PH_BUILD: begin
                    if (is_ident_char(i_char)) begin
                        // prerelease numeric identifiers take no leading zero
                        if (in_pre && r_id_zero && is_digit(i_char)) begin
                            n_error = 1'b1;
                        end else begin
                            n_id_zero = in_pre && !r_id_has && (i_char == CH_ZERO);
                            n_id_has  = 1'b1;
                        end
                    end else if (!r_id_has) begin
                        n_error = 1'b1;
                    end else if (i_char == CH_DOT) begin
                        n_id_has  = 1'b0;
                        n_id_zero = 1'b0;
                    end else if (i_char == CH_PLUS && in_pre) begin
                        n_phase      = PH_BUILD;
                        n_build_seen = 1'b1;
                        n_id_has     = 1'b0;
                        n_id_zero    = 1'b0;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                default: begin
                    n_error = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        valid = !r_error &&
                (((r_phase == PH_PATCH) && num_ok) ||
                 ((r_phase inside {PH_PRE, PH_BUILD}) && r_id_has));
        o_result.is_valid  = valid;
        o_result.major     = valid ? OUT_NUM_W'(r_major[OutW-1:0]) : '0;
        o_result.minor     = valid ? OUT_NUM_W'(r_minor[OutW-1:0]) : '0;
        o_result.patch     = valid ? OUT_NUM_W'(r_acc[OutW-1:0])   : '0;
        o_result.has_pre   = valid && r_pre_seen;
        o_result.has_build = valid && r_build_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAJOR;
            r_dcount     <= DC_NONE;
            r_acc        <= '0;
            r_major      <= '0;
            r_minor      <= '0;
            r_first_zero <= 1'b0;
            r_ovf        <= 1'b0;
            r_id_has     <= 1'b0;
            r_id_zero    <= 1'b0;
            r_error      <= 1'b0;
            r_pre_seen   <= 1'b0;
            r_build_seen <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_dcount     <= n_dcount;
            r_acc        <= n_acc;
            r_major      <= n_major;
            r_minor      <= n_minor;
            r_first_zero <= n_first_zero;
            r_ovf        <= n_ovf;
            r_id_has     <= n_id_has;
            r_id_zero    <= n_id_zero;
            r_error      <= n_error;
            r_pre_seen   <= n_pre_seen;
            r_build_seen <= n_build_seen;
        end
    end

endmodule

// ===== design/semv_out_reg.sv =====
// Result register for the semantic version checker output stream.
// Depends on semv_pkg.
module semv_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  semv_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output semv_pkg::t_result o_result
);
    import semv_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== design/semver_string_validator.sv =====
// Semantic version string checker: input register, parser, result register.
// A result shows on m_axis_tvalid once its end item, transferred into the input
// register, moves on from the input register into the result register.
// Throughput: one character or end item per cycle; the parse state takes one
// update per cycle. A stalled output holds back the input only once an end
// item is waiting for the result register.
// Reset (synchronous, active low) clears the parse state and both valid flags.
// Depends on semv_pkg, semv_parser and semv_out_reg.
module semver_string_validator #(
    parameter int NUMBER_WIDTH = semv_pkg::NUM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] char_byte
    input  logic                             s_axis_tlast,  // end_of_string
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] major_value, [63:32] minor_value, [95:64] patch_value,
    // [96] has_prerelease, [97] has_build, rest zero
    output logic [semv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tuser   // is_valid
);
    import semv_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    logic    out_free;
    logic    step;
    t_result parse_res;
    t_result out_res;

    // A character always advances; an end item waits for room in the
    // result register.
    assign step          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload until the next transfer
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    semv_parser #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (parse_res)
    );

    // Load the verdict when the end item advances
    semv_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && r_in_last),
        .i_result (parse_res),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (out_free),
        .o_result (out_res)
    );

    assign m_axis_tuser = out_res.is_valid;
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.has_build, out_res.has_pre,
                           out_res.patch, out_res.minor, out_res.major};

endmodule

// ===== design/semv_checker.sv =====
// Port-level checks for the semantic version checker, bound to the top level.
// Depends on semv_pkg and semver_string_validator.
module semv_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [semv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);
    import semv_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An invalid verdict carries no numbers or flags
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid result with non-zero payload");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
        else $error("padding bits set");

    // Reset drops the output valid
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind semver_string_validator semv_checker u_semv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/semver_string_validator_tb.sv =====
// Self-checking testbench for semver_string_validator: streams version strings
// a byte per transfer and checks every result against a built-in parser model.
// Depends on semv_pkg and the RTL of the block only.
module semver_string_validator_tb;
    import semv_pkg::*;

    localparam int          NUMBER_WIDTH   = NUM_WIDTH_DEF;
    // Largest number that fits NUMBER_WIDTH bits, held at 64 bits
    localparam logic [63:0] NUM_LIMIT      = {64{1'b1}} >> (64 - NUMBER_WIDTH);
    localparam int          RANDOM_ITEMS   = 1000;
    localparam int          OUTPUT_HOLD    = 400;   // long receiver hold-off, in cycles
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam string       TAG_CHARS      =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-";

    // Parser model and result store. Every accepted byte or end marker goes
    // through note_input; every accepted result goes through check_result.
    class semver_scoreboard;
        t_phase      ph;
        logic [63:0] acc;
        t_dcount     dcount;
        logic        lead_zero;
        logic        ovf;
        logic [63:0] major_q;
        logic [63:0] minor_q;
        logic        id_has;
        logic        id_zero;
        logic        err;
        logic        pre_seen;
        logic        bld_seen;
        t_result     versions_due[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart_parse();
        endfunction

        function void clear_number();
            acc       = '0;
            dcount    = DC_NONE;
            lead_zero = 1'b0;
            ovf       = 1'b0;
        endfunction

        function void clear_ident();
            id_has  = 1'b0;
            id_zero = 1'b0;
        endfunction

        function void restart_parse();
            ph       = PH_MAJOR;
            clear_number();
            major_q  = '0;
            minor_q  = '0;
            clear_ident();
            err      = 1'b0;
            pre_seen = 1'b0;
            bld_seen = 1'b0;
        endfunction

        function bit is_num_char(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_tag_char(logic [7:0] c);
            return is_num_char(c) || (c >= CH_LO_A && c <= CH_LO_Z) ||
                   (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_DASH;
        endfunction

        function void take_number_char(logic [7:0] c);
            logic [63:0] d;
            if (is_num_char(c)) begin
                d = 64'(c - CH_ZERO);
                // A digit after a leading zero is a leading-zero error
                if (dcount != DC_NONE && lead_zero) begin
                    err = 1'b1;
                    return;
                end
                if (dcount == DC_NONE)
                    lead_zero = (c == CH_ZERO);
                if (acc > (NUM_LIMIT - d) / 10)
                    ovf = 1'b1;
                else
                    acc = acc * 10 + d;
                dcount = (dcount == DC_NONE) ? DC_ONE : DC_MANY;
                return;
            end
            if (dcount == DC_NONE || ovf) begin
                err = 1'b1;
                return;
            end
            if (c == CH_DOT && ph == PH_MAJOR) begin
                major_q = acc;
                ph      = PH_MINOR;
                clear_number();
            end else if (c == CH_DOT && ph == PH_MINOR) begin
                minor_q = acc;
                ph      = PH_PATCH;
                clear_number();
            end else if (c == CH_DASH && ph == PH_PATCH) begin
                ph       = PH_PRE;
                pre_seen = 1'b1;
                clear_ident();
            end else if (c == CH_PLUS && ph == PH_PATCH) begin
                ph       = PH_BUILD;
                bld_seen = 1'b1;
                clear_ident();
            end else begin
                err = 1'b1;
            end
        endfunction

        function void take_tag_char(logic [7:0] c);
            bit pre;
            pre = (ph == PH_PRE);
            if (is_tag_char(c)) begin
                // A prerelease identifier may not carry a digit after a leading zero
                if (pre && id_zero && is_num_char(c)) begin
                    err = 1'b1;
                    return;
                end
                id_zero = pre && !id_has && c == CH_ZERO;
                id_has  = 1'b1;
                return;
            end
            if (!id_has) begin
                err = 1'b1;
                return;
            end
            if (c == CH_DOT) begin
                clear_ident();
            end else if (c == CH_PLUS && pre) begin
                ph       = PH_BUILD;
                bld_seen = 1'b1;
                clear_ident();
            end else begin
                err = 1'b1;
            end
        endfunction

        function void note_input(logic [7:0] c, logic last);
            t_result res;
            bit      ok;
            if (!last) begin
                if (err)
                    return;
                if (ph == PH_MAJOR || ph == PH_MINOR || ph == PH_PATCH)
                    take_number_char(c);
                else
                    take_tag_char(c);
                return;
            end
            if (err)
                ok = 1'b0;
            else if (ph == PH_PATCH)
                ok = dcount != DC_NONE && !ovf;
            else if (ph == PH_PRE || ph == PH_BUILD)
                ok = id_has;
            else
                ok = 1'b0;
            res = '0;
            if (ok) begin
                res.is_valid  = 1'b1;
                res.major     = major_q[OUT_NUM_W-1:0];
                res.minor     = minor_q[OUT_NUM_W-1:0];
                res.patch     = acc[OUT_NUM_W-1:0];
                res.has_pre   = pre_seen;
                res.has_build = bld_seen;
            end
            versions_due.insert(versions_due.size(), res);
            restart_parse();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic valid_flag);
            t_result want;
            if (versions_due.size() == 0) begin
                $display("%0t: result with no version pending, expected none, got %h/%b",
                         $time, data, valid_flag);
                mismatches++;
                return;
            end
            want = versions_due.pop_front();
            compare_field("is_valid", want.is_valid, valid_flag);
            compare_field("major", want.major, data[OUT_NUM_W-1:0]);
            compare_field("minor", want.minor, data[2*OUT_NUM_W-1:OUT_NUM_W]);
            compare_field("patch", want.patch, data[3*OUT_NUM_W-1:2*OUT_NUM_W]);
            compare_field("has_prerelease", want.has_pre, data[3*OUT_NUM_W]);
            compare_field("has_build", want.has_build, data[3*OUT_NUM_W+1]);
            compare_field("padding", '0, data[OUT_TDATA_W-1:OUT_FIELDS_W]);
        endfunction

        function int pending();
            return versions_due.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] char_byte
    logic                   s_axis_tlast;   // end_of_string
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [31:0] major, [63:32] minor, [95:64] patch, [96] prerelease, [97] build
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;   // is_valid

    semver_scoreboard sb;
    logic [7:0]       text_q[$];     // characters of the string being built
    int unsigned      sent_items;
    int unsigned      stall_cycles;
    bit               hold_output;   // asks the receiver for one long hold-off

    semver_string_validator #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int unsigned pick_idle(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte or end marker and hold it until the transfer completes
    task automatic send_item(input logic [7:0] ch, input logic last, input bit quiet);
        int unsigned gap;
        gap = pick_idle(quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(ch, last);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Send the built string followed by its end marker; the byte carried by
    // the end marker is random, since the block must ignore it
    task automatic send_text();
        bit quiet;
        quiet = ($urandom_range(0, 3) == 0);
        foreach (text_q[i])
            send_item(text_q[i], 1'b0, quiet);
        send_item(8'($urandom_range(0, 255)), 1'b1, quiet);
        text_q.delete();
    endtask

    // Append one character to the string being built
    task automatic append_char(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endtask

    task automatic add_number();
        logic [63:0] value;
        case ($urandom_range(0, 9))
            0, 1, 2: value = $urandom_range(0, 9);
            3, 4:    value = $urandom_range(10, 99999);
            5:       value = 64'd4294967290 + $urandom_range(0, 10);  // straddle the limit
            6:       value = {$urandom, $urandom};                     // far too wide
            7: begin
                append_char(CH_ZERO);                                  // leading zero
                value = $urandom_range(0, 99);
            end
            default: value = $urandom;
        endcase
        add_text($sformatf("%0d", value));
    endtask

    task automatic add_ident();
        int unsigned n;
        case ($urandom_range(0, 7))
            0: append_char(CH_ZERO);
            1: add_text($sformatf("0%0d", $urandom_range(0, 99)));
            2: add_text($sformatf("%0d", $urandom_range(1, 999)));
            default: begin
                n = $urandom_range(1, 4);
                repeat (n) append_char(TAG_CHARS[$urandom_range(0, TAG_CHARS.len() - 1)]);
            end
        endcase
    endtask

    task automatic add_tag();
        int unsigned n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                append_char(CH_DOT);
            add_ident();
        end
    endtask

    // Break a well-formed string in one place
    task automatic mutate_text();
        int unsigned pos;
        logic [7:0]  marks[4];
        marks = '{CH_DOT, CH_DASH, CH_PLUS, CH_ZERO};
        if (text_q.size() == 0)
            return;
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 4))
            0: text_q[pos] = 8'($urandom_range(0, 255));
            1: text_q.insert(pos, 8'($urandom_range(0, 255)));
            2: text_q.delete(pos);
            3: text_q[pos] = marks[$urandom_range(0, 3)];
            default: while (text_q.size() > pos) void'(text_q.pop_back());
        endcase
    endtask

    task automatic build_random_version();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            // Pure noise, every byte value possible
            n = $urandom_range(0, 12);
            repeat (n) append_char(8'($urandom_range(0, 255)));
            return;
        end
        add_number();
        append_char(CH_DOT);
        add_number();
        append_char(CH_DOT);
        add_number();
        if ($urandom_range(0, 9) < 4) begin
            append_char(CH_DASH);
            add_tag();
        end
        if ($urandom_range(0, 9) < 4) begin
            append_char(CH_PLUS);
            add_tag();
        end
        if (r < 25)
            mutate_text();
    endtask

    // Receiver: random hold-offs, quiet stretches, and one long hold-off on
    // request so that the block backs up into its input
    initial begin
        int unsigned gap;
        int unsigned quiet_left;
        m_axis_tready = 1'b0;
        quiet_left    = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                gap = OUTPUT_HOLD;
            end else if (quiet_left > 0) begin
                quiet_left--;
                gap = 0;
            end else begin
                if ($urandom_range(0, 9) < 2)
                    quiet_left = $urandom_range(5, 20);
                gap = pick_idle(1'b0);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
            @(negedge i_clk);
        end
    end

    // Watchdog: abort when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        string directed[$];
        int unsigned random_start;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        sent_items    = 0;
        stall_cycles  = 0;
        hold_output   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: number extremes, overflow, leading zeros, tag rules,
        // empty and truncated strings, stray characters
        directed = '{"0.0.0", "1.2.3", "4294967295.4294967295.4294967295",
                     "4294967296.1.1", "1.2.99999999999", "01.2.3", "1.00.3",
                     "1.2.3-alpha.1", "1.2.3-0", "1.2.3-01", "1.2.3-0a.0-x",
                     "1.2.3+build.007", "1.2.3-rc.1+B-7.x", "", "1.2", "1.2.3-",
                     "1.2.3+", "1.2.3-a..b", "1.2.3+a+b", "1.2.3-a.", "1.2.3.4",
                     "v1.2.3", ".1.2.3"};
        foreach (directed[i]) begin
            add_text(directed[i]);
            send_text();
        end
        add_text("1.");
        append_char(8'h00);
        add_text("2.3");
        send_text();
        add_text("1.2.3-a");
        append_char(8'hFF);
        send_text();
        add_text("1.2.3+b");
        append_char(8'h80);
        send_text();

        // Random: mostly well-formed versions with random content; ask for
        // the long output hold-off at the start so the input backs up
        hold_output  = 1'b1;
        random_start = sent_items;
        while (sent_items - random_start < RANDOM_ITEMS) begin
            build_random_version();
            send_text();
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every outstanding result, then a little longer
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/semv_pkg.sv
design/semv_parser.sv
design/semv_out_reg.sv
design/semver_string_validator.sv
design/semv_checker.sv
dv/semver_string_validator_tb.sv
